// ===== hw/rtl/angle_gyro_kalman_fusion_defines.svh =====
// Assertion macros for the filter RTL, included by the sequencer.
`ifndef ANGLE_GYRO_KALMAN_FUSION_DEFINES_SVH
`define ANGLE_GYRO_KALMAN_FUSION_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define AGKF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define AGKF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/agkf_pkg.sv =====
package agkf_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE  = 8'd3;

  localparam logic [23:0] TIME_STEP_RST   = 24'd16777;
  localparam logic [30:0] ANGLE_NOISE_RST = 31'd1073742;
  localparam logic [30:0] BIAS_NOISE_RST  = 31'd3221225;
  localparam logic [30:0] MEAS_NOISE_RST  = 31'd32212255;

  // 1.0 in Q2.30.
  localparam logic signed [31:0] COV_ONE = 32'sh4000_0000;

  // Multiply-accumulate operations of one filter step, in issue order.
  typedef enum logic [3:0] {
    OP_ANG_PRED,
    OP_AA_PRED,
    OP_AB_PRED,
    OP_ANG_COR,
    OP_BIAS_COR,
    OP_BA_UPD,
    OP_BB_UPD,
    OP_AA_UPD,
    OP_AB_UPD
  } op_e;

  typedef struct packed {
    logic ld_in;
    logic mul_start;
    logic wb;
    op_e  op;
    logic div_start;
    logic ld_k;
    logic ld_out;
  } ctl_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
  } sts_t;

endpackage

// ===== hw/rtl/angle_gyro_kalman_fusion.sv =====
// Channel   Direction  Handshake              Payload
// ------------------------------------------------------------------------
// sample    in         in_valid_i/in_stall_o   measured_angle_i, gyro_rate_i
// result    out        out_valid_o/out_stall_i filtered_angle_o
// config    in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Each accepted sample makes nine passes through the shared multiplier and one
// through the two-lane gain divider, which retires one quotient bit per cycle,
// and ends with one final step that loads the result register.
// Reset is asynchronous and active low; it loads the register defaults, zeroes
// the estimates and sets both diagonal covariance terms to one.
// A result that is stalled at the output does not block the next sample from
// being accepted; the sequencer only holds in its final step until the output
// register is free.
//
// Two-state Kalman filter: angle and gyro bias estimates with a 2x2 covariance.
// The prediction advances the angle by the bias-corrected rate times the time
// step and propagates the covariance with the process noise terms. The gains
// are the first covariance column divided by the measurement noise plus the
// angle variance, and the correction step updates the estimates and the
// covariance. The first sample seeds the angle from the measurement. The
// configuration registers are always ready; writes are expected only while the
// filter is idle, and writes to unknown indexes are ignored.
module angle_gyro_kalman_fusion #(
  parameter int DATA_WIDTH = agkf_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [31:0]              measured_angle_i,
  input  logic signed [31:0]              gyro_rate_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [31:0]              filtered_angle_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [agkf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [agkf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  agkf_pkg::ctl_t ctl;
  agkf_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  // The sequencer issues one command at a time and waits on unit status.
  agkf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // The datapath holds all filter state and the arithmetic units.
  agkf_dp #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .meas_i     (measured_angle_i),
    .rate_i     (gyro_rate_i),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .angle_o    (filtered_angle_o)
  );

endmodule

// ===== hw/rtl/agkf_mul.sv =====
// Sign-magnitude multiplier with truncation toward zero. One 32x32 array is
// used twice for the low and high halves of the wide operand.
module agkf_mul #(
  parameter int AW = 33
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [AW:0]   a_i,
  input  logic signed [32:0]   b_i,
  input  logic                 sh30_i,
  output logic                 done_o,
  output logic signed [AW+8:0] r_o
);

  logic [1:0]          step_q;
  logic                done_q;
  logic [AW-1:0]       ma_q;
  logic [31:0]         mb_q;
  logic                neg_q;
  logic                sh30_q;
  logic [63:0]         lo_q;
  logic [AW-1:0]       hi_q;
  logic signed [AW+8:0] r_q;

  logic signed [AW:0]  a_abs;
  logic signed [32:0]  b_abs;
  logic [31:0]         mul_x;
  logic [63:0]         prod;
  logic [AW+31:0]      full;
  logic [AW+31:0]      shifted;
  logic [AW+7:0]       mag;

  assign a_abs = a_i[AW] ? -a_i : a_i;
  assign b_abs = b_i[32] ? -b_i : b_i;

  assign mul_x = (step_q == 2'd1) ? ma_q[31:0] : 32'(ma_q[AW-1:32]);
  assign prod  = 64'(mul_x) * 64'(mb_q);

  assign full    = {hi_q, 32'b0} + (AW+32)'(lo_q);
  assign shifted = sh30_q ? (full >> 30) : (full >> 24);
  assign mag     = shifted[AW+7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= (step_q == 2'd3);
      if (start_i) begin
        step_q <= 2'd1;
      end else if (step_q != 2'd0) begin
        step_q <= step_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q   <= a_abs[AW-1:0];
      mb_q   <= b_abs[31:0];
      neg_q  <= a_i[AW] ^ b_i[32];
      sh30_q <= sh30_i;
    end
    if (step_q == 2'd1) begin
      lo_q <= prod;
    end
    if (step_q == 2'd2) begin
      hi_q <= prod[AW-1:0];
    end
    if (step_q == 2'd3) begin
      r_q <= neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  assign done_o = done_q;
  assign r_o    = r_q;

endmodule

// ===== hw/rtl/agkf_div.sv =====
// Two-lane restoring divider for the gains: k = sat32((x << 30) / e), truncated
// toward zero, zero when e is zero. Both lanes share the divisor.
module agkf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] x0_i,
  input  logic signed [31:0] x1_i,
  input  logic signed [32:0] e_i,
  output logic               done_o,
  output logic signed [31:0] k0_o,
  output logic signed [31:0] k1_o
);

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic        zero_q;
  logic [32:0] d_q;
  logic        neg_q [2];
  logic        ovf_q [2];
  logic [33:0] rem_q [2];
  logic [31:0] low_q [2];
  logic [31:0] quo_q [2];

  logic signed [31:0] x_in  [2];
  logic [31:0]        x_mag [2];
  logic signed [32:0] e_abs;
  logic [33:0]        trial [2];
  logic               ge    [2];
  logic signed [31:0] k_res [2];

  assign x_in[0] = x0_i;
  assign x_in[1] = x1_i;
  assign e_abs   = e_i[32] ? -e_i : e_i;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      x_mag[i] = x_in[i][31] ? 32'(-x_in[i]) : 32'(x_in[i]);
      trial[i] = {rem_q[i][32:0], low_q[i][31]};
      ge[i]    = trial[i] >= {1'b0, d_q};
      if (zero_q) begin
        k_res[i] = '0;
      end else if (!neg_q[i]) begin
        k_res[i] = (ovf_q[i] || quo_q[i][31]) ? 32'sh7FFF_FFFF : $signed(quo_q[i]);
      end else begin
        k_res[i] = (ovf_q[i] || (quo_q[i] > 32'h8000_0000)) ? 32'sh8000_0000
                                                              : -$signed(quo_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      zero_q <= (e_i == '0);
      d_q    <= e_abs[32:0];
      for (int i = 0; i < 2; i++) begin
        neg_q[i] <= x_in[i][31] ^ e_i[32];
        ovf_q[i] <= {3'b0, x_mag[i][31:2]} >= e_abs[32:0];
        rem_q[i] <= {4'b0, x_mag[i][31:2]};
        low_q[i] <= {x_mag[i][1:0], 30'b0};
        quo_q[i] <= '0;
      end
    end else if (busy_q) begin
      for (int i = 0; i < 2; i++) begin
        rem_q[i] <= ge[i] ? (trial[i] - {1'b0, d_q}) : trial[i];
        quo_q[i] <= {quo_q[i][30:0], ge[i]};
        low_q[i] <= {low_q[i][30:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign k0_o   = k_res[0];
  assign k1_o   = k_res[1];

endmodule

// ===== hw/rtl/agkf_ctrl.sv =====
`include "angle_gyro_kalman_fusion_defines.svh"

// Sequencer: steps through the nine multiply operations and the gain division.
module agkf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  agkf_pkg::sts_t sts_i,
  output agkf_pkg::ctl_t ctl_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DIVW  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]      state_q, state_d;
  agkf_pkg::op_e   op_q, op_d, op_next;
  logic            out_vld_q, out_vld_d;

  always_comb begin
    case (op_q)
      agkf_pkg::OP_ANG_PRED: op_next = agkf_pkg::OP_AA_PRED;
      agkf_pkg::OP_AA_PRED:  op_next = agkf_pkg::OP_AB_PRED;
      agkf_pkg::OP_ANG_COR:  op_next = agkf_pkg::OP_BIAS_COR;
      agkf_pkg::OP_BIAS_COR: op_next = agkf_pkg::OP_BA_UPD;
      agkf_pkg::OP_BA_UPD:   op_next = agkf_pkg::OP_BB_UPD;
      agkf_pkg::OP_BB_UPD:   op_next = agkf_pkg::OP_AA_UPD;
      agkf_pkg::OP_AA_UPD:   op_next = agkf_pkg::OP_AB_UPD;
      default:               op_next = agkf_pkg::OP_ANG_PRED;
    endcase
  end

  always_comb begin
    ctl_o           = '0;
    ctl_o.op        = op_q;
    ctl_o.ld_in     = (state_q == ST_IDLE) && in_valid_i;
    ctl_o.mul_start = (state_q == ST_ISSUE);
    ctl_o.wb        = (state_q == ST_WAIT) && sts_i.mul_done;
    ctl_o.div_start = (state_q == ST_DIV);
    ctl_o.ld_k      = (state_q == ST_DIVW) && sts_i.div_done;
    ctl_o.ld_out    = (state_q == ST_FIN) && (!out_vld_q || !out_stall_i);

    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_ISSUE;
          op_d    = agkf_pkg::OP_ANG_PRED;
        end
      end
      ST_ISSUE: state_d = ST_WAIT;
      ST_WAIT: begin
        if (sts_i.mul_done) begin
          if (op_q == agkf_pkg::OP_AB_PRED) begin
            state_d = ST_DIV;
          end else if (op_q == agkf_pkg::OP_AB_UPD) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_ISSUE;
            op_d    = op_next;
          end
        end
      end
      ST_DIV: state_d = ST_DIVW;
      ST_DIVW: begin
        if (sts_i.div_done) begin
          state_d = ST_ISSUE;
          op_d    = agkf_pkg::OP_ANG_COR;
        end
      end
      ST_FIN: begin
        if (!out_vld_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_vld_d = out_vld_q;
    if (ctl_o.ld_out) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= agkf_pkg::OP_ANG_PRED;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;

  `AGKF_ASSERT_IMP(a_no_overwrite, ctl_o.ld_out, !out_vld_q || !out_stall_i,
                   "result register overwritten while its transaction is pending")
  `AGKF_ASSERT_IMP(a_mul_done_in_wait, sts_i.mul_done, state_q == ST_WAIT,
                   "multiplier finished outside a wait state")
  `AGKF_ASSERT_IMP(a_div_done_in_wait, sts_i.div_done, state_q == ST_DIVW,
                   "divider finished outside its wait state")
  `AGKF_ASSERT_NXT(a_issue_to_wait, state_q == ST_ISSUE, state_q == ST_WAIT,
                   "multiply issue not followed by wait")

endmodule

// ===== hw/rtl/agkf_dp.sv =====
// Datapath: configuration registers, filter state, operand selection,
// saturating write-back, shared multiplier and gain divider.
module agkf_dp #(
  parameter int DATA_WIDTH = agkf_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [agkf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [agkf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic signed [31:0]              meas_i,
  input  logic signed [31:0]              rate_i,
  input  agkf_pkg::ctl_t                  ctl_i,
  output agkf_pkg::sts_t                  sts_o,
  output logic signed [31:0]              angle_o
);

  localparam int W  = DATA_WIDTH;
  localparam int XW = (W > 32) ? W : 32;
  localparam int AW = XW + 1;
  localparam int SA = XW + 2;
  localparam int RW = AW + 9;
  localparam int SW = RW + 2;

  localparam logic signed [SW-1:0] MAXW  = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] MINW  = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [SW-1:0] MAX32 = {{(SW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SW-1:0] MIN32 = {{(SW-31){1'b1}}, {31{1'b0}}};

  function automatic logic signed [W-1:0] satw_f(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] c;
    c = (v > MAXW) ? MAXW : ((v < MINW) ? MINW : v);
    return c[W-1:0];
  endfunction

  function automatic logic signed [31:0] sat32_f(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] c;
    c = (v > MAX32) ? MAX32 : ((v < MIN32) ? MIN32 : v);
    return c[31:0];
  endfunction

  logic [23:0] dt_q;
  logic [30:0] apn_q, bpn_q, rn_q;

  logic signed [W-1:0]  angle_q, bias_q;
  logic signed [31:0]   aa_q, ab_q, ba_q, bb_q;
  logic                 seeded_q;
  logic signed [31:0]   meas_q, rate_q;
  logic signed [SA-1:0] err_q;
  logic signed [31:0]   k0_q, k1_q;
  logic signed [31:0]   out_q;

  logic signed [SA-1:0] mul_a;
  logic signed [32:0]   mul_b;
  logic                 mul_sh30;
  logic                 mul_done;
  logic signed [RW-1:0] mul_r;

  logic                 div_done;
  logic signed [31:0]   div_k0, div_k1;
  logic signed [32:0]   div_e;

  logic signed [SW-1:0] r_ext, base, addend, sum, sum_ba;
  logic signed [SW-1:0] bb_sum;
  logic                 sub;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a    = '0;
    mul_b    = $signed({9'b0, dt_q});
    mul_sh30 = 1'b0;
    case (ctl_i.op) inside
      agkf_pkg::OP_ANG_PRED: mul_a = SA'(rate_q) - SA'(bias_q);
      agkf_pkg::OP_AA_PRED:  mul_a = -(SA'(ab_q) + SA'(ba_q));
      agkf_pkg::OP_AB_PRED:  mul_a = -SA'(bb_q);
      agkf_pkg::OP_ANG_COR: begin
        mul_a = err_q;  mul_b = 33'(k0_q); mul_sh30 = 1'b1;
      end
      agkf_pkg::OP_BIAS_COR: begin
        mul_a = err_q;  mul_b = 33'(k1_q); mul_sh30 = 1'b1;
      end
      agkf_pkg::OP_BA_UPD: begin
        mul_a = SA'(aa_q); mul_b = 33'(k1_q); mul_sh30 = 1'b1;
      end
      agkf_pkg::OP_BB_UPD: begin
        mul_a = SA'(ab_q); mul_b = 33'(k1_q); mul_sh30 = 1'b1;
      end
      agkf_pkg::OP_AA_UPD: begin
        mul_a = SA'(aa_q); mul_b = 33'(k0_q); mul_sh30 = 1'b1;
      end
      agkf_pkg::OP_AB_UPD: begin
        mul_a = SA'(ab_q); mul_b = 33'(k0_q); mul_sh30 = 1'b1;
      end
      default: mul_a = '0;
    endcase
  end

  // Write-back accumulate: base plus or minus the product, plus any noise term.
  always_comb begin
    r_ext  = SW'(mul_r);
    base   = '0;
    addend = '0;
    sub    = 1'b0;
    case (ctl_i.op) inside
      agkf_pkg::OP_ANG_PRED, agkf_pkg::OP_ANG_COR: base = SW'(angle_q);
      agkf_pkg::OP_BIAS_COR: base = SW'(bias_q);
      agkf_pkg::OP_AA_PRED: begin
        base   = SW'(aa_q);
        addend = SW'($signed({1'b0, apn_q}));
      end
      agkf_pkg::OP_AB_PRED: base = SW'(ab_q);
      agkf_pkg::OP_AA_UPD: begin
        base = SW'(aa_q); sub = 1'b1;
      end
      agkf_pkg::OP_AB_UPD: begin
        base = SW'(ab_q); sub = 1'b1;
      end
      agkf_pkg::OP_BA_UPD: begin
        base = SW'(ba_q); sub = 1'b1;
      end
      agkf_pkg::OP_BB_UPD: begin
        base = SW'(bb_q); sub = 1'b1;
      end
      default: base = '0;
    endcase
    sum    = base + (sub ? -r_ext : r_ext) + addend;
    sum_ba = SW'(ba_q) + r_ext;
    bb_sum = SW'(bb_q) + SW'($signed({1'b0, bpn_q}));
  end

  assign div_e = $signed({2'b0, rn_q}) + 33'(aa_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q     <= agkf_pkg::TIME_STEP_RST;
      apn_q    <= agkf_pkg::ANGLE_NOISE_RST;
      bpn_q    <= agkf_pkg::BIAS_NOISE_RST;
      rn_q     <= agkf_pkg::MEAS_NOISE_RST;
      angle_q  <= '0;
      bias_q   <= '0;
      aa_q     <= agkf_pkg::COV_ONE;
      ab_q     <= '0;
      ba_q     <= '0;
      bb_q     <= agkf_pkg::COV_ONE;
      seeded_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          agkf_pkg::REG_TIME_STEP:   dt_q  <= cfg_data_i[23:0];
          agkf_pkg::REG_ANGLE_NOISE: apn_q <= cfg_data_i[30:0];
          agkf_pkg::REG_BIAS_NOISE:  bpn_q <= cfg_data_i[30:0];
          agkf_pkg::REG_MEAS_NOISE:  rn_q  <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (ctl_i.ld_in && !seeded_q) begin
        seeded_q <= 1'b1;
        angle_q  <= satw_f(SW'(meas_i));
      end
      if (ctl_i.wb) begin
        case (ctl_i.op) inside
          agkf_pkg::OP_ANG_PRED, agkf_pkg::OP_ANG_COR: angle_q <= satw_f(sum);
          agkf_pkg::OP_BIAS_COR: bias_q <= satw_f(sum);
          agkf_pkg::OP_AA_PRED, agkf_pkg::OP_AA_UPD: aa_q <= sat32_f(sum);
          agkf_pkg::OP_AB_PRED: begin
            ab_q <= sat32_f(sum);
            ba_q <= sat32_f(sum_ba);
            bb_q <= sat32_f(bb_sum);
          end
          agkf_pkg::OP_AB_UPD: ab_q <= sat32_f(sum);
          agkf_pkg::OP_BA_UPD: ba_q <= sat32_f(sum);
          agkf_pkg::OP_BB_UPD: bb_q <= sat32_f(sum);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_in) begin
      meas_q <= meas_i;
      rate_q <= rate_i;
    end
    if (ctl_i.ld_k) begin
      k0_q  <= div_k0;
      k1_q  <= div_k1;
      err_q <= SA'(meas_q) - SA'(angle_q);
    end
    if (ctl_i.ld_out) begin
      out_q <= sat32_f(SW'(angle_q));
    end
  end

  agkf_mul #(
    .AW(AW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(ctl_i.mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .sh30_i (mul_sh30),
    .done_o (mul_done),
    .r_o    (mul_r)
  );

  agkf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(ctl_i.div_start),
    .x0_i   (aa_q),
    .x1_i   (ba_q),
    .e_i    (div_e),
    .done_o (div_done),
    .k0_o   (div_k0),
    .k1_o   (div_k1)
  );

  assign sts_o.mul_done = mul_done;
  assign sts_o.div_done = div_done;
  assign angle_o        = out_q;

endmodule
